@@ src/mfq_pkg.sv @@
// Package with shared constants, types and codes of the feedback scheduler.
`timescale 1ns / 1ps
package mfq_pkg;

    localparam int MAX_TASKS   = 16;
    localparam int QUEUE_DEPTH = 16;
    localparam int LEVELS      = 4;
    localparam int TASK_W      = $clog2(MAX_TASKS);
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int LEVEL_W     = 2;
    localparam int QADDR_W     = LEVEL_W + QIDX_W;
    localparam int SCAN_W      = $clog2(MAX_TASKS + 1);

    localparam logic [1:0] TOP_LEVEL = 2'd3;
    localparam logic [7:0] TIMEOUT_RESET = 8'd20;
    localparam logic [4:0] TOTAL_RESET   = 5'd16;

    localparam logic CFG_TIMEOUT    = 1'b0;
    localparam logic CFG_TASK_TOTAL = 1'b1;

    typedef enum logic [2:0] {
        EV_TIMEOUT  = 3'd0,
        EV_START    = 3'd1,
        EV_RUNNING  = 3'd2,
        EV_END      = 3'd3,
        EV_SUSPEND  = 3'd4,
        EV_IDLE     = 3'd5,
        EV_ALL_DONE = 3'd6
    } event_t;

    typedef struct packed {
        logic arrive;
        logic scan_clr;
        logic scan_step;
        logic pop;
        logic take;
        logic ev_start;
        logic ev_run;
        logic post;
        logic idle_ev;
        logic done_step;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic scan_empty;
        logic scan_last;
        logic q_any;
        logic pop_live;
    } status_t;

endpackage

@@ src/mfq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/mfq_ctrl.sv @@
// Controller state machine that sequences arrivals and scheduler ticks.
`timescale 1ns / 1ps
module mfq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             mode,
    input  mfq_pkg::status_t status,
    output logic             busy,
    output mfq_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_POP, S_POPWAIT, S_START, S_RUN, S_POST, S_IDLE_EV, S_DONE, S_FLUSH
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (!mode)
                    begin
                        cmd.arrive = 1'b1;
                    end
                    else
                    begin
                        cmd.scan_clr = 1'b1;
                        state_next = status.scan_empty ? S_POP : S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (status.q_any)
                begin
                    cmd.pop = 1'b1;
                    state_next = S_POPWAIT;
                end
                else
                begin
                    state_next = S_IDLE_EV;
                end
            end
            S_POPWAIT:
            begin
                cmd.take = 1'b1;
                state_next = status.pop_live ? S_START : S_POP;
            end
            S_START:
            begin
                cmd.ev_start = 1'b1;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                cmd.ev_run = 1'b1;
                state_next = S_POST;
            end
            S_POST:
            begin
                cmd.post = 1'b1;
                state_next = S_DONE;
            end
            S_IDLE_EV:
            begin
                cmd.idle_ev = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.done_step = 1'b1;
                state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                cmd.flush = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ src/mfq_dp.sv @@
// Datapath with task tables, ready queues, counters and the result register.
`timescale 1ns / 1ps
module mfq_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mfq_pkg::cmd_t               cmd,
    output mfq_pkg::status_t            status,
    input  logic                        cfg_wr,
    input  logic                        cfg_index,
    input  logic [7:0]                  cfg_data,
    input  logic [3:0]                  task_id,
    input  logic [7:0]                  burst_length,
    input  logic [1:0]                  base_priority,
    output logic                        res_valid,
    output logic [2:0]                  event_res,
    output logic [15:0]                 time_stamp,
    output logic [3:0]                  task_number,
    output logic [1:0]                  level,
    output logic [7:0]                  remaining,
    output logic                        last
);

    localparam int TW = mfq_pkg::TASK_W;
    localparam int QW = mfq_pkg::QIDX_W;
    localparam int CW = mfq_pkg::QCNT_W;
    localparam int AW = mfq_pkg::QADDR_W;
    localparam int SW = mfq_pkg::SCAN_W;

    typedef struct packed {
        logic [2:0]  ev;
        logic [15:0] ts;
        logic [3:0]  id;
        logic [1:0]  lv;
        logic [7:0]  rem;
    } res_t;

    logic [7:0]    limit_reg;
    logic [4:0]    total_reg;
    logic [15:0]   tick_reg;
    logic [4:0]    done_cnt_reg;
    logic [SW-1:0] idx_reg;
    logic [TW-1:0] cur_reg;

    logic [7:0]    rem_reg   [mfq_pkg::MAX_TASKS];
    logic [7:0]    wait_reg  [mfq_pkg::MAX_TASKS];
    logic          arr_reg   [mfq_pkg::MAX_TASKS];
    logic [7:0]    burst_reg [mfq_pkg::MAX_TASKS];
    logic [1:0]    base_reg  [mfq_pkg::MAX_TASKS];
    logic [1:0]    lvl_reg   [mfq_pkg::MAX_TASKS];
    logic [QW-1:0] head_reg  [mfq_pkg::LEVELS];
    logic [CW-1:0] cnt_reg   [mfq_pkg::LEVELS];

    res_t pend_reg;
    logic pend_v_reg;
    res_t out_reg;
    logic out_v_reg;
    logic out_last_reg;

    logic [SW-1:0] scan_lim;
    logic [TW-1:0] si;
    logic [TW-1:0] arr_id;
    logic [7:0]    wait_inc;
    logic          scan_hit;
    logic          scan_kill;
    logic [1:0]    pop_q;
    logic          all_done;
    logic [7:0]    cur_rem;
    logic [1:0]    cur_lv;
    logic [1:0]    next_lv;
    logic [15:0]   tick_inc;
    logic          bump;
    logic          emit_v;
    res_t          emit;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [3:0]    ram_rdata;
    logic [1:0]    push_q;
    logic          push_fr;
    logic          push_en;
    logic [TW-1:0] push_id;

    assign scan_lim = (total_reg > 5'(mfq_pkg::MAX_TASKS)) ? SW'(mfq_pkg::MAX_TASKS)
                                                            : SW'(total_reg);
    assign si       = idx_reg[TW-1:0];
    assign arr_id   = task_id[TW-1:0];
    assign wait_inc = (wait_reg[si] == 8'hFF) ? 8'hFF : wait_reg[si] + 8'd1;
    assign scan_hit = arr_reg[si] && (rem_reg[si] != 8'd0);
    assign scan_kill = scan_hit && (wait_inc >= limit_reg);
    assign all_done = (done_cnt_reg >= total_reg);
    assign cur_rem  = rem_reg[cur_reg];
    assign cur_lv   = lvl_reg[cur_reg];
    assign next_lv  = (cur_lv < mfq_pkg::TOP_LEVEL) ? cur_lv + 2'd1 : mfq_pkg::TOP_LEVEL;
    assign tick_inc = tick_reg + 16'd1;
    assign push_id  = cmd.arrive ? arr_id : cur_reg;

    always_comb
    begin
        pop_q = 2'd3;
        for (int q = mfq_pkg::LEVELS - 1; q >= 0; q--)
        begin
            if (cnt_reg[q] != '0)
            begin
                pop_q = 2'(q);
            end
        end
    end

    assign status.scan_empty = (scan_lim == '0);
    assign status.scan_last  = ((idx_reg + SW'(1)) >= scan_lim);
    assign status.q_any      = (cnt_reg[0] != '0) || (cnt_reg[1] != '0) ||
                               (cnt_reg[2] != '0) || (cnt_reg[3] != '0);
    assign status.pop_live   = (rem_reg[ram_rdata[TW-1:0]] != 8'd0);

    always_comb
    begin
        emit_v  = 1'b0;
        emit    = '0;
        bump    = 1'b0;
        push_en = 1'b0;
        push_fr = 1'b0;
        push_q  = base_priority;
        if (cmd.arrive)
        begin
            push_en = 1'b1;
        end
        if (cmd.scan_step && scan_kill)
        begin
            emit_v = 1'b1;
            emit   = '{mfq_pkg::EV_TIMEOUT, tick_reg, 4'(si), lvl_reg[si], rem_reg[si]};
            bump   = 1'b1;
        end
        if (cmd.ev_start && (cur_rem == burst_reg[cur_reg]))
        begin
            emit_v = 1'b1;
            emit   = '{mfq_pkg::EV_START, tick_reg, 4'(cur_reg), cur_lv, cur_rem};
        end
        if (cmd.ev_run)
        begin
            emit_v = 1'b1;
            emit   = '{mfq_pkg::EV_RUNNING, tick_reg, 4'(cur_reg), cur_lv, cur_rem};
        end
        if (cmd.post)
        begin
            if (cur_rem == 8'd0)
            begin
                emit_v = 1'b1;
                emit   = '{mfq_pkg::EV_END, tick_inc, 4'(cur_reg), cur_lv, 8'd0};
                bump   = 1'b1;
            end
            else if (base_reg[cur_reg] == 2'd0)
            begin
                push_en = 1'b1;
                push_fr = 1'b1;
                push_q  = 2'd0;
            end
            else
            begin
                emit_v  = 1'b1;
                emit    = '{mfq_pkg::EV_SUSPEND, tick_inc, 4'(cur_reg), next_lv, cur_rem};
                push_en = 1'b1;
                push_q  = next_lv;
            end
        end
        if (cmd.idle_ev && !all_done)
        begin
            emit_v = 1'b1;
            emit   = '{mfq_pkg::EV_IDLE, tick_reg, 4'd0, 2'd0, 8'd0};
        end
        if (cmd.done_step && all_done)
        begin
            emit_v = 1'b1;
            emit   = '{mfq_pkg::EV_ALL_DONE, tick_reg, 4'd0, 2'd0, 8'd0};
        end
    end

    assign ram_we    = push_en && (cnt_reg[push_q] < CW'(mfq_pkg::QUEUE_DEPTH));
    assign ram_waddr = push_fr ? {push_q, head_reg[push_q] - QW'(1)}
                               : {push_q, head_reg[push_q] + cnt_reg[push_q][QW-1:0]};
    assign ram_raddr = {pop_q, head_reg[pop_q]};

    mfq_ram #(
        .WIDTH (4),
        .DEPTH (mfq_pkg::LEVELS * mfq_pkg::QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (4'(push_id)),
        .re    (cmd.pop),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= mfq_pkg::TIMEOUT_RESET;
            total_reg    <= mfq_pkg::TOTAL_RESET;
            tick_reg     <= '0;
            done_cnt_reg <= '0;
            idx_reg      <= '0;
            for (int i = 0; i < mfq_pkg::MAX_TASKS; i++)
            begin
                rem_reg[i]  <= '0;
                wait_reg[i] <= '0;
                arr_reg[i]  <= 1'b0;
            end
            for (int q = 0; q < mfq_pkg::LEVELS; q++)
            begin
                head_reg[q] <= '0;
                cnt_reg[q]  <= '0;
            end
        end
        else
        begin
            if (cfg_wr)
            begin
                if (cfg_index == mfq_pkg::CFG_TIMEOUT)
                begin
                    limit_reg <= cfg_data;
                end
                else
                begin
                    total_reg <= cfg_data[4:0];
                end
            end
            if (bump && (done_cnt_reg != 5'd31))
            begin
                done_cnt_reg <= done_cnt_reg + 5'd1;
            end
            if (cmd.done_step && !all_done)
            begin
                tick_reg <= tick_inc;
            end
            if (cmd.scan_clr)
            begin
                idx_reg <= '0;
            end
            if (cmd.arrive)
            begin
                rem_reg[arr_id]  <= burst_length;
                wait_reg[arr_id] <= '0;
                arr_reg[arr_id]  <= 1'b1;
            end
            if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + SW'(1);
                if (scan_hit)
                begin
                    wait_reg[si] <= wait_inc;
                end
                if (scan_kill)
                begin
                    rem_reg[si] <= '0;
                end
            end
            if (cmd.pop)
            begin
                head_reg[pop_q] <= head_reg[pop_q] + QW'(1);
                cnt_reg[pop_q]  <= cnt_reg[pop_q] - CW'(1);
            end
            if (cmd.ev_run)
            begin
                wait_reg[cur_reg] <= '0;
                rem_reg[cur_reg]  <= cur_rem - 8'd1;
            end
            if (ram_we)
            begin
                cnt_reg[push_q] <= cnt_reg[push_q] + CW'(1);
                if (push_fr)
                begin
                    head_reg[push_q] <= head_reg[push_q] - QW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.arrive)
        begin
            burst_reg[arr_id] <= burst_length;
            base_reg[arr_id]  <= base_priority;
            lvl_reg[arr_id]   <= base_priority;
        end
        if (cmd.take)
        begin
            cur_reg <= ram_rdata[TW-1:0];
        end
        if (cmd.post && (cur_rem != 8'd0) && (base_reg[cur_reg] != 2'd0))
        begin
            lvl_reg[cur_reg] <= next_lv;
        end
        if (emit_v)
        begin
            pend_reg <= emit;
        end
        if ((emit_v || cmd.flush) && pend_v_reg)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= cmd.flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            out_v_reg <= (emit_v || cmd.flush) && pend_v_reg;
            if (cmd.flush)
            begin
                pend_v_reg <= 1'b0;
            end
            else if (emit_v)
            begin
                pend_v_reg <= 1'b1;
            end
        end
    end

    assign res_valid   = out_v_reg;
    assign event_res   = out_reg.ev;
    assign time_stamp  = out_reg.ts;
    assign task_number = out_reg.id;
    assign level       = out_reg.lv;
    assign remaining   = out_reg.rem;
    assign last        = out_last_reg;

endmodule

@@ src/multilevel_feedback_scheduler_top.sv @@
// Top level of the four-level feedback scheduler.
//
// Channel   Direction  Handshake             Payload
// command   in         start, busy           mode, task_id, burst_length, base_priority
// config    in         cfg_valid, cfg_ready  cfg_index, cfg_data
// result    out        res_valid             event_res, time_stamp, task_number, level,
//                                            remaining, last
//
// An arrival never raises busy. After a tick is accepted, busy stays high while the
// controller scans the first min(task_total, 16) task table entries, pops queue entries
// through the single queue memory port until a live task is found, runs it or takes the
// idle state, and then steps the done and flush states; the final result transfer happens
// in the first cycle with busy low again.
// Reset clears all control state at once; no clearing pass is needed.
// Each result transfer lasts one cycle and the receiver cannot stall it.
`timescale 1ns / 1ps
module multilevel_feedback_scheduler_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [3:0]  task_id,
    input  logic [7:0]  burst_length,
    input  logic [1:0]  base_priority,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        res_valid,
    output logic [2:0]  event_res,
    output logic [15:0] time_stamp,
    output logic [3:0]  task_number,
    output logic [1:0]  level,
    output logic [7:0]  remaining,
    output logic        last
);

    mfq_pkg::cmd_t    cmd;
    mfq_pkg::status_t status;

    assign cfg_ready = 1'b1;

    mfq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    mfq_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .task_id       (task_id),
        .burst_length  (burst_length),
        .base_priority (base_priority),
        .res_valid     (res_valid),
        .event_res     (event_res),
        .time_stamp    (time_stamp),
        .task_number   (task_number),
        .level         (level),
        .remaining     (remaining),
        .last          (last)
    );

endmodule

@@ dv/mfq_checker.sv @@
// Checker that predicts the scheduler's event stream and compares every result transfer.
`timescale 1ns / 1ps
module mfq_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        mode,
    input  logic [3:0]  task_id,
    input  logic [7:0]  burst_length,
    input  logic [1:0]  base_priority,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        res_valid,
    input  logic [2:0]  event_res,
    input  logic [15:0] time_stamp,
    input  logic [3:0]  task_number,
    input  logic [1:0]  level,
    input  logic [7:0]  remaining,
    input  logic        last,
    output int          fails,
    output int          pending
);

    typedef struct packed {
        mfq_pkg::event_t ev;
        logic [15:0]     ts;
        logic [3:0]      tn;
        logic [1:0]      lv;
        logic [7:0]      rem;
        logic            lst;
    } sched_event_t;

    sched_event_t event_queue[$];

    logic [7:0]  limit_reg;
    logic [4:0]  total_reg;
    logic [15:0] ticks;
    logic [4:0]  done_cnt;
    logic [7:0]  rem_tab  [mfq_pkg::MAX_TASKS];
    logic [7:0]  burst_tab[mfq_pkg::MAX_TASKS];
    logic [1:0]  prio_tab [mfq_pkg::MAX_TASKS];
    logic [1:0]  lvl_tab  [mfq_pkg::MAX_TASKS];
    logic [7:0]  wait_tab [mfq_pkg::MAX_TASKS];
    logic        seen_tab [mfq_pkg::MAX_TASKS];
    logic [3:0]  qstore   [mfq_pkg::LEVELS][mfq_pkg::QUEUE_DEPTH];
    logic [3:0]  qhead    [mfq_pkg::LEVELS];
    logic [4:0]  qcnt     [mfq_pkg::LEVELS];
    sched_event_t tick_out[$];

    function automatic void note(mfq_pkg::event_t ev, logic [15:0] ts, logic [3:0] tn,
                                 logic [1:0] lv, logic [7:0] rem);
        sched_event_t e;
        if (tick_out.size() >= 20)
        begin
            return;
        end
        e.ev = ev;
        e.ts = ts;
        e.tn = tn;
        e.lv = lv;
        e.rem = rem;
        e.lst = 1'b0;
        tick_out.push_back(e);
    endfunction

    function automatic void count_done();
        if (done_cnt < 5'd31)
        begin
            done_cnt++;
        end
    endfunction

    function automatic void enqueue_back(int q, logic [3:0] id);
        if (qcnt[q] >= mfq_pkg::QUEUE_DEPTH)
        begin
            return;
        end
        qstore[q][4'(qhead[q] + qcnt[q][3:0])] = id;
        qcnt[q]++;
    endfunction

    function automatic void run_tick();
        int scan, reports;
        logic [15:0] t;
        logic [3:0] id;
        logic found;
        logic [7:0] r;
        logic [1:0] lv, nl;
        sched_event_t e;
        t = ticks;
        reports = 0;
        found = 1'b0;
        id = '0;
        tick_out.delete();
        scan = (total_reg < mfq_pkg::MAX_TASKS) ? int'(total_reg) : mfq_pkg::MAX_TASKS;
        for (int i = 0; i < scan; i++)
        begin
            if (seen_tab[i] && rem_tab[i] != 0)
            begin
                if (wait_tab[i] != 8'hFF)
                begin
                    wait_tab[i]++;
                end
                if (wait_tab[i] >= limit_reg)
                begin
                    if (reports < 16)
                    begin
                        note(mfq_pkg::EV_TIMEOUT, t, 4'(i), lvl_tab[i], rem_tab[i]);
                        reports++;
                    end
                    rem_tab[i] = 0;
                    count_done();
                end
            end
        end
        for (int q = 0; q < mfq_pkg::LEVELS && !found; q++)
        begin
            while (qcnt[q] != 0 && !found)
            begin
                id = qstore[q][qhead[q]];
                qhead[q]++;
                qcnt[q]--;
                if (rem_tab[id] != 0)
                begin
                    found = 1'b1;
                end
            end
        end
        if (found)
        begin
            lv = lvl_tab[id];
            r = rem_tab[id];
            wait_tab[id] = 0;
            if (r == burst_tab[id])
            begin
                note(mfq_pkg::EV_START, t, id, lv, r);
            end
            note(mfq_pkg::EV_RUNNING, t, id, lv, r);
            r--;
            rem_tab[id] = r;
            if (r == 0)
            begin
                note(mfq_pkg::EV_END, t + 16'd1, id, lv, 8'd0);
                count_done();
            end
            else if (prio_tab[id] == 0)
            begin
                if (qcnt[0] < mfq_pkg::QUEUE_DEPTH)
                begin
                    qhead[0]--;
                    qstore[0][qhead[0]] = id;
                    qcnt[0]++;
                end
            end
            else
            begin
                nl = (lv < mfq_pkg::TOP_LEVEL) ? lv + 2'd1 : mfq_pkg::TOP_LEVEL;
                note(mfq_pkg::EV_SUSPEND, t + 16'd1, id, nl, r);
                lvl_tab[id] = nl;
                enqueue_back(nl, id);
            end
        end
        else if (done_cnt < total_reg)
        begin
            note(mfq_pkg::EV_IDLE, t, 4'd0, 2'd0, 8'd0);
        end
        if (done_cnt >= total_reg)
        begin
            note(mfq_pkg::EV_ALL_DONE, t, 4'd0, 2'd0, 8'd0);
        end
        else
        begin
            ticks++;
        end
        if (tick_out.size() > 0)
        begin
            tick_out[tick_out.size() - 1].lst = 1'b1;
        end
        foreach (tick_out[k])
        begin
            e = tick_out[k];
            event_queue.push_back(e);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sched_event_t got, want;
        if (!rst_n)
        begin
            fails <= 0;
            event_queue.delete();
            pending = 0;
            limit_reg = mfq_pkg::TIMEOUT_RESET;
            total_reg = mfq_pkg::TOTAL_RESET;
            ticks = '0;
            done_cnt = '0;
            for (int i = 0; i < mfq_pkg::MAX_TASKS; i++)
            begin
                rem_tab[i] = '0;
                wait_tab[i] = '0;
                seen_tab[i] = 1'b0;
                burst_tab[i] = '0;
                prio_tab[i] = '0;
                lvl_tab[i] = '0;
            end
            for (int q = 0; q < mfq_pkg::LEVELS; q++)
            begin
                qhead[q] = '0;
                qcnt[q] = '0;
            end
        end
        else
        begin
            if (res_valid)
            begin
                got.ev = mfq_pkg::event_t'(event_res);
                got.ts = time_stamp;
                got.tn = task_number;
                got.lv = level;
                got.rem = remaining;
                got.lst = last;
                if (event_queue.size() == 0)
                begin
                    if (fails < 10)
                    begin
                        $display("Unexpected result: ev=%0d ts=%0d task=%0d lv=%0d rem=%0d last=%0b",
                                 event_res, time_stamp, task_number, level, remaining, last);
                    end
                    fails <= fails + 1;
                end
                else
                begin
                    want = event_queue.pop_front();
                    if (got !== want)
                    begin
                        if (fails < 10)
                        begin
                            $display("Mismatch: expected ev=%0d ts=%0d task=%0d lv=%0d rem=%0d last=%0b",
                                     want.ev, want.ts, want.tn, want.lv, want.rem, want.lst);
                            $display("          actual   ev=%0d ts=%0d task=%0d lv=%0d rem=%0d last=%0b",
                                     got.ev, got.ts, got.tn, got.lv, got.rem, got.lst);
                        end
                        fails <= fails + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == mfq_pkg::CFG_TIMEOUT)
                begin
                    limit_reg = cfg_data;
                end
                else
                begin
                    total_reg = cfg_data[4:0];
                end
            end
            if (start && !busy)
            begin
                if (mode)
                begin
                    run_tick();
                end
                else
                begin
                    rem_tab[task_id] = burst_length;
                    burst_tab[task_id] = burst_length;
                    prio_tab[task_id] = base_priority;
                    lvl_tab[task_id] = base_priority;
                    wait_tab[task_id] = '0;
                    seen_tab[task_id] = 1'b1;
                    enqueue_back(base_priority, task_id);
                end
            end
            pending = event_queue.size();
        end
    end

endmodule

@@ dv/tb_top.sv @@
// Testbench top: drives arrivals, ticks and register writes into the scheduler.
`timescale 1ns / 1ps
module tb_top;

    localparam int STALL_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        mode = 1'b0;
    logic [3:0]  task_id = '0;
    logic [7:0]  burst_length = '0;
    logic [1:0]  base_priority = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = '0;
    logic        res_valid;
    logic [2:0]  event_res;
    logic [15:0] time_stamp;
    logic [3:0]  task_number;
    logic [1:0]  level;
    logic [7:0]  remaining;
    logic        last;
    int          fails;
    int          pending;
    int          stall_cycles = 0;

    always #5 clk = ~clk;

    multilevel_feedback_scheduler_top uut (.*);
    mfq_checker checker_i (.*);

    always @(posedge clk)
    begin
        if ((start && !busy) || res_valid || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_item(logic m, logic [3:0] id, logic [7:0] b, logic [1:0] p);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        mode <= m;
        task_id <= id;
        burst_length <= b;
        base_priority <= p;
        do @(posedge clk); while (busy);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        start <= 1'b0;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            b = 8'd255;
        end
        else if (r < 7)
        begin
            b = 8'd0;
        end
        else if (r < 15)
        begin
            b = 8'($urandom_range(1, 255));
        end
        else
        begin
            b = 8'($urandom_range(1, 6));
        end
        send_item($urandom_range(0, 99) < 50, 4'($urandom_range(0, 15)), b,
                  2'($urandom_range(0, 3)));
    endtask

    initial
    begin
        logic [7:0] limits [5];
        logic [7:0] totals [5];
        limits = '{8'd20, 8'd1, 8'd255, 8'd7, 8'd3};
        totals = '{8'd16, 8'd16, 8'd3, 8'd0, 8'd16};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(1'b1, 4'd0, 8'd1, 2'd0);
        send_item(1'b0, 4'd0, 8'd3, 2'd0);
        send_item(1'b0, 4'd15, 8'd255, 2'd3);
        send_item(1'b0, 4'd5, 8'd2, 2'd1);
        send_item(1'b0, 4'd9, 8'd0, 2'd2);
        send_item(1'b0, 4'd10, 8'd1, 2'd2);
        send_item(1'b0, 4'd5, 8'd4, 2'd1);
        for (int i = 0; i < 12; i++)
        begin
            send_item(1'b1, 4'd0, 8'd1, 2'd0);
        end
        for (int i = 0; i < 17; i++)
        begin
            send_item(1'b0, 4'd7, 8'd2, 2'd3);
        end

        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph > 0)
            begin
                write_reg(mfq_pkg::CFG_TIMEOUT, limits[ph]);
                write_reg(mfq_pkg::CFG_TASK_TOTAL, totals[ph]);
            end
            for (int i = 0; i < 60; i++)
            begin
                if (i == 30)
                begin
                    start <= 1'b0;
                    wait_drained();
                end
                random_item();
            end
        end
        start <= 1'b0;
        wait_drained();
        if (fails == 0 && pending == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
